FILE: hw/rtl/adl32fr_pkg.sv
// Shared types and constants for the Adler-32 framed packet receiver.
// Holds the phase and result-kind codes, framing bytes and register indexes.
// Depends on nothing.
`default_nettype none

package adl32fr_pkg;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CMD  = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_CSUM = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        K_DATA   = 2'd0,
        K_ACCEPT = 2'd1,
        K_LENREJ = 2'd2,
        K_SUMREJ = 2'd3
    } kind_t;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd1;

    localparam logic [15:0] MIN_LENGTH_RESET = 16'd1;
    localparam logic [15:0] MAX_LENGTH_RESET = 16'hFFFF;

    localparam logic [31:0] MAX_PAYLOAD = 32'd65535;
    localparam logic [16:0] ADLER_MOD   = 17'd65521;

    localparam logic [15:0] PREAMBLE_HEAD = 16'hFF00;
    localparam logic [7:0]  PREAMBLE_TAIL = 8'h7F;

endpackage

`default_nettype wire

FILE: hw/rtl/adler32_frame_receiver.sv
// Framed packet receiver with Adler-32 payload check, top level.
// Uses adl32fr_pkg for phase and kind codes, limits and framing constants.
//
// Usage: received serial bytes enter on the s_ channel (s_valid, s_ready,
// s_rx_byte), one byte per request. The block hunts for the preamble
// FF 00 7F, reads a little-endian command word and length word, forwards
// each payload byte on the m_ channel as a tentative request, and then
// reports a verdict (accepted, length rejected or checksum rejected).
// Hunting, command, length and checksum bytes other than the last give no
// result. The result of a byte is registered in the output register in the
// cycle after it is accepted. A new byte can be accepted in every cycle
// while the output register is empty or being read; the phase logic and
// Adler-32 modular adds are one registered pass. When the output register
// is full and m_ready is low, s_ready drops until the result is taken.
// A synchronous low on aresetn returns the receiver to hunting, empties
// the output register and restores min_length to 1 and max_length to 65535.
// The user writes limit registers (cfg_we, cfg_index, cfg_wdata) only
// while idle, which the block does not enforce; other indexes are ignored.
`default_nettype none

module adler32_frame_receiver #(
    parameter logic [31:0] MAX_PAYLOAD = adl32fr_pkg::MAX_PAYLOAD
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,

    input  wire                                  cfg_we,
    input  wire  [adl32fr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [15:0]                          cfg_wdata,

    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  [7:0]                           s_rx_byte,

    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic [1:0]                           m_kind,
    output logic signed [31:0]                   m_command,
    output logic [15:0]                          m_length,
    output logic [7:0]                           m_data_byte
);

    logic [15:0] min_length_reg;
    logic [15:0] max_length_reg;

    adl32fr_pkg::phase_t phase_reg, phase_next;
    logic [15:0] prev_bytes_reg, prev_bytes_next;
    logic [1:0]  hunt_fill_reg, hunt_fill_next;
    logic [1:0]  field_pos_reg, field_pos_next;
    logic [31:0] command_reg, command_next;
    logic [31:0] length_reg, length_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] sum_a_reg, sum_a_next;
    logic [15:0] sum_b_reg, sum_b_next;
    logic [31:0] checksum_reg, checksum_next;

    logic        m_valid_reg;
    logic [1:0]  m_kind_reg;
    logic [31:0] m_command_reg;
    logic [15:0] m_length_reg;
    logic [7:0]  m_data_byte_reg;

    logic        in_accept;
    logic        emit;
    logic [1:0]  emit_kind;
    logic [15:0] emit_length;
    logic [7:0]  emit_data;

    logic [31:0] full_length;
    logic [31:0] full_checksum;
    logic [15:0] sat_length;
    logic        length_bad;
    logic [16:0] a_sum;
    logic [15:0] a_mod;
    logic [16:0] b_sum;
    logic [15:0] b_mod;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_command   = m_command_reg;
    assign m_length    = m_length_reg;
    assign m_data_byte = m_data_byte_reg;

    always_comb begin
        full_length   = {s_rx_byte, length_reg[23:0]};
        full_checksum = {s_rx_byte, checksum_reg[23:0]};

        if (full_length[31]) begin
            sat_length = 16'd0;
        end else if (full_length[30:16] != 15'd0) begin
            sat_length = 16'hFFFF;
        end else begin
            sat_length = full_length[15:0];
        end

        length_bad = full_length[31]
                  || (full_length < {16'd0, min_length_reg})
                  || (full_length > {16'd0, max_length_reg})
                  || (full_length > MAX_PAYLOAD);

        a_sum = {1'b0, sum_a_reg} + {9'd0, s_rx_byte};
        if (a_sum >= adl32fr_pkg::ADLER_MOD) begin
            a_mod = 16'(a_sum - adl32fr_pkg::ADLER_MOD);
        end else begin
            a_mod = a_sum[15:0];
        end
        b_sum = {1'b0, sum_b_reg} + {1'b0, a_mod};
        if (b_sum >= adl32fr_pkg::ADLER_MOD) begin
            b_mod = 16'(b_sum - adl32fr_pkg::ADLER_MOD);
        end else begin
            b_mod = b_sum[15:0];
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        prev_bytes_next = prev_bytes_reg;
        hunt_fill_next  = hunt_fill_reg;
        field_pos_next  = field_pos_reg;
        command_next    = command_reg;
        length_next     = length_reg;
        bytes_left_next = bytes_left_reg;
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        checksum_next   = checksum_reg;
        emit            = 1'b0;
        emit_kind       = adl32fr_pkg::K_DATA;
        emit_length     = 16'd0;
        emit_data       = 8'd0;

        case (phase_reg)
            adl32fr_pkg::PH_CMD: begin
                case (field_pos_reg)
                    2'd0:    command_next = {24'd0, s_rx_byte};
                    2'd1:    command_next[15:8] = s_rx_byte;
                    2'd2:    command_next[23:16] = s_rx_byte;
                    default: command_next[31:24] = s_rx_byte;
                endcase
                if (field_pos_reg == 2'd3) begin
                    phase_next     = adl32fr_pkg::PH_LEN;
                    field_pos_next = 2'd0;
                end else begin
                    field_pos_next = field_pos_reg + 2'd1;
                end
            end

            adl32fr_pkg::PH_LEN: begin
                case (field_pos_reg)
                    2'd0:    length_next = {24'd0, s_rx_byte};
                    2'd1:    length_next[15:8] = s_rx_byte;
                    2'd2:    length_next[23:16] = s_rx_byte;
                    default: length_next = full_length;
                endcase
                if (field_pos_reg != 2'd3) begin
                    field_pos_next = field_pos_reg + 2'd1;
                end else begin
                    field_pos_next = 2'd0;
                    if (full_length == 32'd0) begin
                        phase_next      = adl32fr_pkg::PH_HUNT;
                        prev_bytes_next = 16'd0;
                        hunt_fill_next  = 2'd0;
                        emit            = 1'b1;
                        emit_kind       = adl32fr_pkg::K_ACCEPT;
                    end else if (length_bad) begin
                        phase_next      = adl32fr_pkg::PH_HUNT;
                        prev_bytes_next = 16'd0;
                        hunt_fill_next  = 2'd0;
                        emit            = 1'b1;
                        emit_kind       = adl32fr_pkg::K_LENREJ;
                        emit_length     = sat_length;
                    end else begin
                        bytes_left_next = full_length[15:0];
                        sum_a_next      = 16'd1;
                        sum_b_next      = 16'd0;
                        phase_next      = adl32fr_pkg::PH_DATA;
                    end
                end
            end

            adl32fr_pkg::PH_DATA: begin
                sum_a_next      = a_mod;
                sum_b_next      = b_mod;
                bytes_left_next = bytes_left_reg - 16'd1;
                if (bytes_left_reg == 16'd1) begin
                    phase_next     = adl32fr_pkg::PH_CSUM;
                    field_pos_next = 2'd0;
                    checksum_next  = 32'd0;
                end
                emit        = 1'b1;
                emit_kind   = adl32fr_pkg::K_DATA;
                emit_length = length_reg[15:0];
                emit_data   = s_rx_byte;
            end

            adl32fr_pkg::PH_CSUM: begin
                case (field_pos_reg)
                    2'd0:    checksum_next[7:0] = s_rx_byte;
                    2'd1:    checksum_next[15:8] = s_rx_byte;
                    2'd2:    checksum_next[23:16] = s_rx_byte;
                    default: checksum_next = full_checksum;
                endcase
                if (field_pos_reg != 2'd3) begin
                    field_pos_next = field_pos_reg + 2'd1;
                end else begin
                    phase_next      = adl32fr_pkg::PH_HUNT;
                    prev_bytes_next = 16'd0;
                    hunt_fill_next  = 2'd0;
                    field_pos_next  = 2'd0;
                    emit            = 1'b1;
                    emit_length     = length_reg[15:0];
                    if (full_checksum == {sum_b_reg, sum_a_reg}) begin
                        emit_kind = adl32fr_pkg::K_ACCEPT;
                    end else begin
                        emit_kind = adl32fr_pkg::K_SUMREJ;
                    end
                end
            end

            default: begin
                if (hunt_fill_reg == 2'd2 && prev_bytes_reg == adl32fr_pkg::PREAMBLE_HEAD
                        && s_rx_byte == adl32fr_pkg::PREAMBLE_TAIL) begin
                    phase_next      = adl32fr_pkg::PH_CMD;
                    field_pos_next  = 2'd0;
                    prev_bytes_next = 16'd0;
                    hunt_fill_next  = 2'd0;
                end else begin
                    phase_next      = adl32fr_pkg::PH_HUNT;
                    prev_bytes_next = {prev_bytes_reg[7:0], s_rx_byte};
                    if (hunt_fill_reg != 2'd2) begin
                        hunt_fill_next = hunt_fill_reg + 2'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_length_reg <= adl32fr_pkg::MIN_LENGTH_RESET;
            max_length_reg <= adl32fr_pkg::MAX_LENGTH_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                adl32fr_pkg::CFG_MIN_LENGTH: min_length_reg <= cfg_wdata;
                adl32fr_pkg::CFG_MAX_LENGTH: max_length_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= adl32fr_pkg::PH_HUNT;
            prev_bytes_reg <= 16'd0;
            hunt_fill_reg  <= 2'd0;
            field_pos_reg  <= 2'd0;
            command_reg    <= 32'd0;
            length_reg     <= 32'd0;
            bytes_left_reg <= 16'd0;
            sum_a_reg      <= 16'd1;
            sum_b_reg      <= 16'd0;
            checksum_reg   <= 32'd0;
        end else if (in_accept) begin
            phase_reg      <= phase_next;
            prev_bytes_reg <= prev_bytes_next;
            hunt_fill_reg  <= hunt_fill_next;
            field_pos_reg  <= field_pos_next;
            command_reg    <= command_next;
            length_reg     <= length_next;
            bytes_left_reg <= bytes_left_next;
            sum_a_reg      <= sum_a_next;
            sum_b_reg      <= sum_b_next;
            checksum_reg   <= checksum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && emit) begin
            m_kind_reg      <= emit_kind;
            m_command_reg   <= command_reg;
            m_length_reg    <= emit_length;
            m_data_byte_reg <= emit_data;
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/adler32_frame_receiver_test.sv
// Self-checking testbench for adler32_frame_receiver: drives framed byte streams with
// random idling and predicts each result with an Adler-32 frame tracker.
// Depends on adl32fr_pkg and the adler32_frame_receiver RTL.
module adler32_frame_receiver_test;

    localparam logic [adl32fr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int REPORT_CAP = 40;

    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        adl32fr_pkg::kind_t kind;
        logic signed [31:0] command;
        logic [15:0]        length;
        logic [7:0]         data_byte;
    } frame_result_t;

    class adler_frame_tracker;
        frame_result_t       pending_results[$];
        logic [15:0]         min_len;
        logic [15:0]         max_len;
        adl32fr_pkg::phase_t stage;
        logic [15:0]         window;
        int                  fill;
        int                  pos;
        logic [31:0]         cmd_word;
        logic [31:0]         len_word;
        logic [31:0]         sum_word;
        int unsigned         left;
        int unsigned         sum_a;
        int unsigned         sum_b;
        int                  seen;

        function new();
            min_len = adl32fr_pkg::MIN_LENGTH_RESET;
            max_len = adl32fr_pkg::MAX_LENGTH_RESET;
            cmd_word = '0;
            len_word = '0;
            sum_word = '0;
            left = 0;
            sum_a = 1;
            sum_b = 0;
            seen = 0;
            restart_hunt();
        endfunction

        function void restart_hunt();
            stage = adl32fr_pkg::PH_HUNT;
            window = '0;
            fill = 0;
            pos = 0;
        endfunction

        function void set_limit(logic [adl32fr_pkg::CFG_IDX_W-1:0] index,
                                logic [15:0] value);
            if (index == adl32fr_pkg::CFG_MIN_LENGTH) begin
                min_len = value;
            end else if (index == adl32fr_pkg::CFG_MAX_LENGTH) begin
                max_len = value;
            end
        endfunction

        function void push_result(adl32fr_pkg::kind_t kind, logic [15:0] len,
                                  logic [7:0] data);
            frame_result_t r;
            r.kind = kind;
            r.command = cmd_word;
            r.length = len;
            r.data_byte = data;
            pending_results.push_back(r);
        endfunction

        function void note_byte(logic [7:0] value);
            logic [15:0] sat;
            case (stage)
                adl32fr_pkg::PH_CMD: begin
                    if (pos == 0) begin
                        cmd_word = '0;
                    end
                    cmd_word[pos*8 +: 8] = value;
                    if (pos == 3) begin
                        stage = adl32fr_pkg::PH_LEN;
                        pos = 0;
                    end else begin
                        pos++;
                    end
                end
                adl32fr_pkg::PH_LEN: begin
                    if (pos == 0) begin
                        len_word = '0;
                    end
                    len_word[pos*8 +: 8] = value;
                    if (pos < 3) begin
                        pos++;
                    end else begin
                        pos = 0;
                        if (len_word == 0) begin
                            restart_hunt();
                            push_result(adl32fr_pkg::K_ACCEPT, 16'd0, 8'd0);
                        end else if (len_word[31] || len_word < min_len
                                     || len_word > max_len
                                     || len_word > adl32fr_pkg::MAX_PAYLOAD) begin
                            if (len_word[31]) begin
                                sat = 16'd0;
                            end else if (len_word > 32'hFFFF) begin
                                sat = 16'hFFFF;
                            end else begin
                                sat = len_word[15:0];
                            end
                            restart_hunt();
                            push_result(adl32fr_pkg::K_LENREJ, sat, 8'd0);
                        end else begin
                            left = len_word[15:0];
                            sum_a = 1;
                            sum_b = 0;
                            stage = adl32fr_pkg::PH_DATA;
                        end
                    end
                end
                adl32fr_pkg::PH_DATA: begin
                    sum_a = sum_a + value;
                    if (sum_a >= adl32fr_pkg::ADLER_MOD) begin
                        sum_a = sum_a - adl32fr_pkg::ADLER_MOD;
                    end
                    sum_b = sum_b + sum_a;
                    if (sum_b >= adl32fr_pkg::ADLER_MOD) begin
                        sum_b = sum_b - adl32fr_pkg::ADLER_MOD;
                    end
                    if (left > 0) begin
                        left--;
                    end
                    if (left == 0) begin
                        stage = adl32fr_pkg::PH_CSUM;
                        pos = 0;
                        sum_word = '0;
                    end
                    push_result(adl32fr_pkg::K_DATA, len_word[15:0], value);
                end
                adl32fr_pkg::PH_CSUM: begin
                    sum_word[pos*8 +: 8] = value;
                    if (pos < 3) begin
                        pos++;
                    end else begin
                        restart_hunt();
                        if (sum_word == {sum_b[15:0], sum_a[15:0]}) begin
                            push_result(adl32fr_pkg::K_ACCEPT, len_word[15:0], 8'd0);
                        end else begin
                            push_result(adl32fr_pkg::K_SUMREJ, len_word[15:0], 8'd0);
                        end
                    end
                end
                default: begin
                    if (fill >= 2 && window == adl32fr_pkg::PREAMBLE_HEAD
                            && value == adl32fr_pkg::PREAMBLE_TAIL) begin
                        stage = adl32fr_pkg::PH_CMD;
                        pos = 0;
                        window = '0;
                        fill = 0;
                    end else begin
                        stage = adl32fr_pkg::PH_HUNT;
                        window = {window[7:0], value};
                        if (fill < 2) begin
                            fill++;
                        end
                    end
                end
            endcase
        endfunction

        function bit check_result(frame_result_t got, output string why);
            frame_result_t want;
            seen++;
            why = "";
            if (pending_results.size() == 0) begin
                why = $sformatf("result %0d arrived with none expected (kind %0d)",
                                seen, got.kind);
                return 1'b0;
            end
            want = pending_results.pop_front();
            if (got.kind != want.kind || got.command != want.command ||
                got.length != want.length || got.data_byte != want.data_byte) begin
                why = $sformatf({"result %0d (got/want): kind %0d/%0d command %h/%h ",
                                 "length %0d/%0d data %h/%h"}, seen, got.kind, want.kind,
                                got.command, want.command, got.length, want.length,
                                got.data_byte, want.data_byte);
                return 1'b0;
            end
            return 1'b1;
        endfunction
    endclass

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [adl32fr_pkg::CFG_IDX_W-1:0]    cfg_index = adl32fr_pkg::CFG_MIN_LENGTH;
    logic [15:0]                          cfg_wdata = '0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic [7:0]                           s_rx_byte = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic [1:0]                           m_kind;
    logic signed [31:0]                   m_command;
    logic [15:0]                          m_length;
    logic [7:0]                           m_data_byte;

    adler_frame_tracker tracker;
    int offer_gap_pct = 0;
    int ready_stall_pct = 0;
    int hold_seq = 0;
    int sent_count = 0;
    int mismatch_count = 0;

    adler32_frame_receiver dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_command   (m_command),
        .m_length    (m_length),
        .m_data_byte (m_data_byte)
    );

    always #4 aclk = ~aclk;

    task automatic report(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP) begin
            $display("%0t: %s", $time, what);
        end
    endtask

    function automatic logic [31:0] payload_checksum(byte_q_t body);
        int unsigned a;
        int unsigned b;
        a = 1;
        b = 0;
        foreach (body[i]) begin
            a = (a + body[i]) % adl32fr_pkg::ADLER_MOD;
            b = (b + a) % adl32fr_pkg::ADLER_MOD;
        end
        return {b[15:0], a[15:0]};
    endfunction

    function automatic logic [7:0] random_byte();
        case ($urandom_range(9))
            0, 1: return 8'hFF;
            2: return 8'h00;
            3: return adl32fr_pkg::PREAMBLE_TAIL;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic byte_q_t random_body(int count);
        byte_q_t body;
        repeat (count) body.push_back(random_byte());
        return body;
    endfunction

    function automatic logic [31:0] random_command();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rejected_length();
        case ($urandom_range(3))
            0: begin
                if (tracker.min_len > 1) begin
                    return $urandom_range(1, tracker.min_len - 1);
                end
            end
            1: begin
                if (tracker.max_len < 16'hFFFF) begin
                    return 32'(tracker.max_len) + $urandom_range(1, 50);
                end
            end
            2: return {1'b1, 31'($urandom)};
            default: return 32'h0001_0000 + $urandom_range(0, 32'h7FFE_FFFF);
        endcase
        return 32'hFFFF_FFFF;
    endfunction

    task automatic push_byte(input logic [7:0] value);
        while ($urandom_range(99) < offer_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= value;
        do @(posedge aclk); while (!s_ready);
        tracker.note_byte(value);
        sent_count++;
    endtask

    task automatic push_word(input logic [31:0] word);
        for (int i = 0; i < 4; i++) begin
            push_byte(word[i*8 +: 8]);
        end
    endtask

    task automatic push_preamble();
        push_byte(adl32fr_pkg::PREAMBLE_HEAD[15:8]);
        push_byte(adl32fr_pkg::PREAMBLE_HEAD[7:0]);
        push_byte(adl32fr_pkg::PREAMBLE_TAIL);
    endtask

    task automatic send_frame(input logic [31:0] cmd, input logic [31:0] len,
                              input byte_q_t body, input bit spoil);
        logic [31:0] check;
        push_preamble();
        push_word(cmd);
        push_word(len);
        if (body.size() != 0) begin
            foreach (body[i]) begin
                push_byte(body[i]);
            end
            check = payload_checksum(body);
            if (spoil) begin
                check = check ^ (32'd1 << $urandom_range(31));
            end
            push_word(check);
        end
    endtask

    task automatic send_random_frame();
        int          pick;
        int          lo;
        int          hi;
        logic [31:0] len;
        byte_q_t     body;
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 6)) push_byte(random_byte());
        end else if (pick < 13) begin
            push_preamble();
            repeat ($urandom_range(1, 10)) push_byte(random_byte());
        end else if (pick < 21) begin
            send_frame(random_command(), 32'd0, body, 1'b0);
        end else if (pick < 33) begin
            send_frame(random_command(), rejected_length(), body, 1'b0);
        end else begin
            lo = (tracker.min_len == 0) ? 1 : int'(tracker.min_len);
            hi = ($urandom_range(9) == 0) ? 64 : 12;
            if (tracker.max_len < hi) begin
                hi = tracker.max_len;
            end
            len = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(1, 12);
            body = random_body(len);
            send_frame(random_command(), len, body, pick >= 88);
        end
    endtask

    task automatic run_random(input int count);
        int start;
        start = sent_count;
        while (sent_count - start < count) begin
            send_random_frame();
        end
    endtask

    task automatic wait_idle(input int extra);
        s_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic set_limits(input logic [15:0] lo, input logic [15:0] hi);
        logic [15:0] junk;
        junk = 16'($urandom);
        cfg_we <= 1'b1;
        cfg_index <= adl32fr_pkg::CFG_MIN_LENGTH;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= adl32fr_pkg::CFG_MAX_LENGTH;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_index <= CFG_UNUSED;
        cfg_wdata <= junk;
        @(posedge aclk);
        cfg_we <= 1'b0;
        tracker.set_limit(adl32fr_pkg::CFG_MIN_LENGTH, lo);
        tracker.set_limit(adl32fr_pkg::CFG_MAX_LENGTH, hi);
        tracker.set_limit(CFG_UNUSED, junk);
    endtask

    initial begin : result_sink
        int            hold_left;
        int            hold_seen;
        frame_result_t got;
        string         why;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.kind = adl32fr_pkg::kind_t'(m_kind);
                got.command = m_command;
                got.length = m_length;
                got.data_byte = m_data_byte;
                if (!tracker.check_result(got, why)) begin
                    report(why);
                end
            end
            if (hold_seen != hold_seq) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= ready_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("adler32_frame_receiver: mismatch");
        $finish;
    end

    initial begin : stimulus
        byte_q_t no_body;
        byte_q_t body;
        tracker = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_limits(adl32fr_pkg::MIN_LENGTH_RESET, adl32fr_pkg::MAX_LENGTH_RESET);

        push_byte(adl32fr_pkg::PREAMBLE_TAIL);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h00);
        send_frame(32'h8000_0000, 32'd0, no_body, 1'b0);
        body.push_back(8'hFF);
        send_frame(32'h7FFF_FFFF, 32'd1, body, 1'b0);
        body.delete();
        body.push_back(8'h00);
        body.push_back(adl32fr_pkg::PREAMBLE_TAIL);
        send_frame(32'd0, 32'd2, body, 1'b1);
        // The length word ends in FF; the following 00 7F must not open a frame.
        send_frame(32'h1234_5678, 32'hFF00_0000, no_body, 1'b0);
        push_byte(8'h00);
        push_byte(adl32fr_pkg::PREAMBLE_TAIL);
        send_frame(32'h5A5A_A5A5, 32'h0001_0000, no_body, 1'b0);
        // A long run of FF bytes carries the running sum a past the modulus.
        body.delete();
        repeat (260) body.push_back(8'hFF);
        send_frame($urandom, 32'd260, body, 1'b0);
        run_random(60);

        wait_idle(4);
        set_limits(16'd0, 16'd0);
        offer_gap_pct = 77;
        run_random(60);

        wait_idle(4);
        set_limits(16'd4, 16'd12);
        offer_gap_pct = 0;
        ready_stall_pct = 77;
        run_random(60);
        hold_seq++;
        run_random(30);
        wait_idle(1);
        run_random(30);

        wait_idle(4);
        set_limits(16'hFFFF, 16'd1);
        offer_gap_pct = 20;
        ready_stall_pct = 20;
        run_random(50);

        wait_idle(4);
        set_limits(16'd2, 16'd40);
        run_random(110);

        wait_idle(10);
        if (tracker.pending_results.size() != 0) begin
            report("expected results never arrived");
        end
        if (mismatch_count == 0) begin
            $display("adler32_frame_receiver: match");
        end else begin
            $display("adler32_frame_receiver: mismatch");
        end
        $finish;
    end
endmodule
